>>> hdl/breakpoint_linear_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Breakpoint interpolator assertion macros
// Shared concurrent assertion forms for the interpolator modules.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_LINEAR_INTERPOLATOR_DEFINES_SVH
`define BREAKPOINT_LINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define BPLI_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define BPLI_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> hdl/bpli_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint interpolator package
// Field widths, item and status codes, state and control types.
// ----------------------------------------------------------------------------
package bpli_pkg;

  localparam int KIND_W    = 2;
  localparam int KEY_W     = 7;
  localparam int AMP_W     = 16;
  localparam int STAT_W    = 2;
  localparam int HELD_W    = 5;
  localparam int PROD_W    = 24;
  localparam int MAG_W     = 23;
  localparam int DIV_CNT_W = 5;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  localparam logic signed [AMP_W-1:0] UNITY_AMP = 16'sd4096;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_FIX,
    ST_RESP
  } bpli_state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic commit;
    logic mul;
    logic div_start;
    logic div_step;
    logic fix;
    logic out_load;
  } bpli_cmd_t;

  typedef struct packed {
    logic start_scan;
    logic scan_last;
    logic interp;
    logic div_done;
    logic out_free;
  } bpli_stat_t;

endpackage

>>> hdl/bpli_ram.sv
// ----------------------------------------------------------------------------
// Breakpoint table RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bpli_datapath.sv
// ----------------------------------------------------------------------------
// Breakpoint interpolator datapath
// Table, scan compare, multiply, restoring divide and output register.
// ----------------------------------------------------------------------------
`include "breakpoint_linear_interpolator_defines.svh"

module bpli_datapath #(
  parameter int MAX_POINTS = 16,
  parameter int KEY_COUNT  = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpli_pkg::bpli_cmd_t                 cmd,
  output bpli_pkg::bpli_stat_t                stat,
  input  logic [bpli_pkg::KIND_W-1:0]         in_kind,
  input  logic [bpli_pkg::KEY_W-1:0]          in_key,
  input  logic signed [bpli_pkg::AMP_W-1:0]   in_amp,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bpli_pkg::AMP_W-1:0]   amplitude_out,
  output logic [bpli_pkg::STAT_W-1:0]         status,
  output logic [bpli_pkg::HELD_W-1:0]         points_held
);

  import bpli_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = KEY_W + AMP_W;

  logic [KIND_W-1:0]       kind_q;
  logic [KEY_W-1:0]        q;
  logic signed [AMP_W-1:0] amp_q;
  logic [CW-1:0]           total;
  logic [IW-1:0]           idx;
  logic                    cmp_vld;
  logic                    dup;
  logic                    have_lo;
  logic                    have_hi;
  logic [KEY_W-1:0]        k_lo;
  logic [KEY_W-1:0]        k_hi;
  logic signed [AMP_W-1:0] y_lo;
  logic signed [AMP_W-1:0] y_hi;
  logic signed [PROD_W-1:0] prod;
  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic [KEY_W-1:0]        rem;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic signed [AMP_W-1:0] res_amp;
  logic [STAT_W-1:0]       res_stat;

  logic [EW-1:0]           rdata;
  logic [KEY_W-1:0]        rk;
  logic signed [AMP_W-1:0] ry;
  logic [KEY_W-1:0]        key_c;
  logic                    full;
  logic                    ram_we;
  logic                    need_interp;
  logic signed [AMP_W:0]   diff;
  logic [KEY_W-1:0]        dq;
  logic [KEY_W-1:0]        den;
  logic signed [PROD_W:0]  prod_full;
  logic signed [PROD_W-1:0] prod_neg;
  logic [KEY_W:0]          rem_s;
  logic                    qbit;
  logic signed [AMP_W+1:0] sq;
  logic signed [AMP_W+1:0] res_full;
  logic signed [AMP_W-1:0] sel_amp;
  logic                    res_between;

  bpli_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total[IW-1:0]),
    .wdata ({q, amp_q}),
    .raddr (idx),
    .rdata (rdata)
  );

  assign rk    = rdata[EW-1:AMP_W];
  assign ry    = rdata[AMP_W-1:0];
  assign key_c = ({1'b0, in_key} >= (KEY_W+1)'(KEY_COUNT)) ? KEY_W'(KEY_COUNT - 1) : in_key;
  assign full  = (total >= CW'(MAX_POINTS));
  assign ram_we = cmd.commit && (kind_q == KIND_APPEND) && !dup && !full;
  assign need_interp = have_lo && have_hi && (k_lo != k_hi);

  assign diff      = {y_hi[AMP_W-1], y_hi} - {y_lo[AMP_W-1], y_lo};
  assign dq        = q - k_lo;
  assign den       = k_hi - k_lo;
  assign prod_full = diff * $signed({1'b0, dq});
  assign prod_neg  = -prod;
  assign rem_s     = {rem, mag[MAG_W-1]};
  assign qbit      = (rem_s >= {1'b0, den});
  assign sq        = $signed({1'b0, mag[AMP_W:0]});
  assign res_full  = {{2{y_lo[AMP_W-1]}}, y_lo} + (neg ? -sq : sq);

  assign res_between = ((y_lo <= y_hi) && (res_amp >= y_lo) && (res_amp <= y_hi)) ||
                       ((y_lo > y_hi) && (res_amp <= y_lo) && (res_amp >= y_hi));

  always_comb begin
    if (!have_lo && !have_hi) begin
      sel_amp = UNITY_AMP;
    end else if (!have_hi) begin
      sel_amp = y_lo;
    end else begin
      sel_amp = y_hi;
    end
  end

  assign stat.start_scan = ((in_kind == KIND_APPEND) || (in_kind == KIND_QUERY)) &&
                           (total != '0);
  assign stat.scan_last  = (CW'(idx) == (total - CW'(1)));
  assign stat.interp     = (kind_q == KIND_QUERY) && need_interp;
  assign stat.div_done   = (div_cnt == DIV_CNT_W'(MAG_W - 1));
  assign stat.out_free   = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_rd;
      if (cmd.commit) begin
        if (kind_q == KIND_CLEAR) begin
          total <= '0;
        end else if (ram_we) begin
          total <= total + CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= in_kind;
      q       <= key_c;
      amp_q   <= in_amp;
      idx     <= '0;
      dup     <= 1'b0;
      have_lo <= 1'b0;
      have_hi <= 1'b0;
    end
    if (cmd.scan_rd) begin
      idx <= idx + IW'(1);
    end
    if (cmp_vld) begin
      if (rk == q) begin
        dup <= 1'b1;
      end
      if ((rk <= q) && (!have_lo || (rk > k_lo))) begin
        have_lo <= 1'b1;
        k_lo    <= rk;
        y_lo    <= ry;
      end
      if ((rk >= q) && (!have_hi || (rk < k_hi))) begin
        have_hi <= 1'b1;
        k_hi    <= rk;
        y_hi    <= ry;
      end
    end
    if (cmd.commit) begin
      case (kind_q)
        KIND_APPEND: begin
          res_amp <= '0;
          if (dup) begin
            res_stat <= STAT_DUP;
          end else if (full) begin
            res_stat <= STAT_FULL;
          end else begin
            res_stat <= STAT_OK;
          end
        end
        KIND_QUERY: begin
          res_amp  <= sel_amp;
          res_stat <= STAT_OK;
        end
        default: begin
          res_amp  <= '0;
          res_stat <= STAT_OK;
        end
      endcase
    end
    if (cmd.mul) begin
      prod <= prod_full[PROD_W-1:0];
    end
    if (cmd.div_start) begin
      neg     <= prod[PROD_W-1];
      mag     <= prod[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod[MAG_W-1:0];
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= qbit ? KEY_W'(rem_s - {1'b0, den}) : rem_s[KEY_W-1:0];
      mag     <= {mag[MAG_W-2:0], qbit};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.fix) begin
      res_amp <= res_full[AMP_W-1:0];
    end
    if (cmd.out_load) begin
      amplitude_out <= res_amp;
      status        <= res_stat;
      points_held   <= HELD_W'(total);
    end
  end

  `BPLI_ASSERT_IMPL(a_write_in_range, clk, rst, ram_we, total < CW'(MAX_POINTS))
  `BPLI_ASSERT_IMPL(a_rem_below_den, clk, rst, cmd.div_step, rem < den)
  `BPLI_ASSERT_NEXT(a_result_bounded, clk, rst, cmd.fix, res_between)

endmodule

>>> hdl/bpli_ctrl.sv
// ----------------------------------------------------------------------------
// Breakpoint interpolator controller
// Sequences scan, update, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
`include "breakpoint_linear_interpolator_defines.svh"

module bpli_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output bpli_pkg::bpli_cmd_t  cmd,
  input  bpli_pkg::bpli_stat_t stat
);

  import bpli_pkg::*;

  bpli_state_t state;
  bpli_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.start_scan ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.commit = 1'b1;
        state_next = stat.interp ? ST_MUL : ST_RESP;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `BPLI_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  `BPLI_ASSERT_NEXT(a_load_once, clk, rst, cmd.out_load, !cmd.out_load)
  `BPLI_ASSERT_NEXT(a_div_ends, clk, rst, cmd.div_step && stat.div_done, cmd.fix)

endmodule

>>> hdl/breakpoint_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Breakpoint linear interpolator
// Breakpoint table with clear, append and piecewise linear query.
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  --------+----------------------+------------------------------------
//  input   | in_valid / in_ready  | kind, key, amplitude
//  output  | out_valid / out_ready| amplitude_out, status, points_held
//
//  Clear, unused kind, or any item on an empty table skips the table scan. Append or
//  plain query with N > 0 points reads the table RAM once per stored point.
//  Interpolating query also runs 23 steps of the restoring divider.
//  Synchronous reset empties the table; stored entries need no clearing.
//  A pending result is held in the output register while the next item enters.
// ----------------------------------------------------------------------------
module breakpoint_linear_interpolator #(
  parameter int MAX_POINTS = 16,
  parameter int KEY_COUNT  = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bpli_pkg::KIND_W-1:0]       kind,
  input  logic [bpli_pkg::KEY_W-1:0]        key,
  input  logic signed [bpli_pkg::AMP_W-1:0] amplitude,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpli_pkg::AMP_W-1:0] amplitude_out,
  output logic [bpli_pkg::STAT_W-1:0]       status,
  output logic [bpli_pkg::HELD_W-1:0]       points_held
);

  import bpli_pkg::*;

  bpli_cmd_t  cmd;
  bpli_stat_t stat;

  bpli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bpli_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .KEY_COUNT  (KEY_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (kind),
    .in_key        (key),
    .in_amp        (amplitude),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .amplitude_out (amplitude_out),
    .status        (status),
    .points_held   (points_held)
  );

endmodule

>>> verif/breakpoint_linear_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint linear interpolator testbench
// Sends clear, append and query items through the valid/ready input with
// random gaps and stalls on both sides. A local copy of the breakpoint table
// predicts each result, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module breakpoint_linear_interpolator_tb;
  import bpli_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int KEY_LIMIT     = 128;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 80;
  localparam int IDLE_PCT      = 37;
  localparam int CALM_FIRST    = 300;
  localparam int CALM_LAST     = 450;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [KEY_W-1:0]        key;
    logic signed [AMP_W-1:0] amp;
  } bp_item_t;

  typedef struct {
    logic signed [AMP_W-1:0] amp;
    logic [STAT_W-1:0]       status;
    logic [HELD_W-1:0]       held;
  } bp_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [KIND_W-1:0]       kind = '0;
  logic [KEY_W-1:0]        key = '0;
  logic signed [AMP_W-1:0] amplitude = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [AMP_W-1:0] amplitude_out;
  logic [STAT_W-1:0]       status;
  logic [HELD_W-1:0]       points_held;

  bp_item_t   pending_items[$];
  bp_result_t awaited_results[$];

  logic [KEY_W-1:0]        table_keys[TABLE_DEPTH];
  logic signed [AMP_W-1:0] table_amps[TABLE_DEPTH];
  int table_count = 0;

  int items_total = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int query_count = 0;
  int interp_count = 0;
  int dup_count = 0;
  int full_count = 0;

  breakpoint_linear_interpolator #(
    .MAX_POINTS(TABLE_DEPTH),
    .KEY_COUNT (KEY_LIMIT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .key          (key),
    .amplitude    (amplitude),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .amplitude_out(amplitude_out),
    .status       (status),
    .points_held  (points_held)
  );

  function automatic logic signed [AMP_W-1:0] interpolate_at(logic [KEY_W-1:0] q);
    bit have_lo = 1'b0;
    bit have_hi = 1'b0;
    int k_lo = 0;
    int k_hi = 0;
    int y_lo = 0;
    int y_hi = 0;
    int qi;
    int k;
    qi = int'(q);
    for (int i = 0; i < table_count; i++) begin
      k = int'(table_keys[i]);
      if (k <= qi && (!have_lo || k > k_lo)) begin
        have_lo = 1'b1;
        k_lo = k;
        y_lo = int'(table_amps[i]);
      end
      if (k >= qi && (!have_hi || k < k_hi)) begin
        have_hi = 1'b1;
        k_hi = k;
        y_hi = int'(table_amps[i]);
      end
    end
    if (!have_lo && !have_hi) return UNITY_AMP;
    if (!have_hi) return AMP_W'(y_lo);
    if (!have_lo || k_lo == k_hi) return AMP_W'(y_hi);
    interp_count++;
    return AMP_W'(y_lo + ((y_hi - y_lo) * (qi - k_lo)) / (k_hi - k_lo));
  endfunction

  function automatic bp_result_t evaluate_item(bp_item_t it);
    bp_result_t r;
    logic [KEY_W-1:0] k;
    bit dup;
    r.amp = '0;
    r.status = STAT_OK;
    dup = 1'b0;
    k = (int'(it.key) >= KEY_LIMIT) ? KEY_W'(KEY_LIMIT - 1) : it.key;
    case (it.kind)
      KIND_CLEAR: table_count = 0;
      KIND_APPEND: begin
        for (int i = 0; i < table_count; i++)
          if (table_keys[i] == k) dup = 1'b1;
        if (dup) begin
          r.status = STAT_DUP;
          dup_count++;
        end else if (table_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
          full_count++;
        end else begin
          table_keys[table_count] = k;
          table_amps[table_count] = it.amp;
          table_count++;
        end
      end
      KIND_QUERY: begin
        r.amp = interpolate_at(k);
        query_count++;
      end
      default: ;
    endcase
    r.held = HELD_W'(table_count);
    return r;
  endfunction

  task automatic add_item(input logic [KIND_W-1:0] kd, input int k, input int a);
    bp_item_t it;
    it.kind = kd;
    it.key  = KEY_W'(k);
    it.amp  = AMP_W'(a);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic int pick_amp();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return 4096;
      4: return int'($urandom_range(0, 128)) - 64;
      default: return int'($urandom & 32'hFFFF);
    endcase
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    bp_item_t it;
    bp_item_t taken;
    bit calm;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.kind = kind;
        taken.key  = key;
        taken.amp  = amplitude;
        awaited_results.insert(awaited_results.size(), evaluate_item(taken));
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        calm = items_accepted >= CALM_FIRST && items_accepted < CALM_LAST;
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          it = pending_items.pop_front();
          in_valid  <= 1'b1;
          kind      <= it.kind;
          key       <= it.key;
          amplitude <= it.amp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    bp_result_t exp_r;
    bit calm;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: amplitude_out %0d status %0d points_held %0d",
                 amplitude_out, status, points_held);
          mismatches++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (amplitude_out !== exp_r.amp) begin
            $error("amplitude_out: expected %0d, got %0d", exp_r.amp, amplitude_out);
            mismatches++;
          end
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            mismatches++;
          end
          if (points_held !== exp_r.held) begin
            $error("points_held: expected %0d, got %0d", exp_r.held, points_held);
            mismatches++;
          end
        end
      end
      calm = results_seen >= CALM_FIRST && results_seen < CALM_LAST;
      out_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  initial begin
    int used_keys[$];
    int directed_total;
    int n_pts;
    int n_q;
    int base;
    int width;
    int k;

    add_item(KIND_QUERY, 0, 32767);
    add_item(KIND_UNUSED, 127, -1);
    add_item(KIND_APPEND, 0, -32768);
    add_item(KIND_APPEND, 127, 32767);
    add_item(KIND_QUERY, 64, 0);
    add_item(KIND_QUERY, 0, 0);
    add_item(KIND_QUERY, 127, 0);
    add_item(KIND_APPEND, 0, 100);
    for (int i = 1; i <= 14; i++)
      add_item(KIND_APPEND, 8 * i, pick_amp());
    add_item(KIND_APPEND, 120, 1);
    add_item(KIND_CLEAR, 127, -32768);
    add_item(KIND_APPEND, 100, 5);
    add_item(KIND_QUERY, 50, 0);
    add_item(KIND_QUERY, 120, 0);
    directed_total = pending_items.size();

    while (pending_items.size() < directed_total + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        add_item(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom);
      end else begin
        if ($urandom_range(0, 99) < 85) begin
          add_item(KIND_CLEAR, $urandom_range(0, 127), $urandom);
          used_keys.delete();
        end
        n_pts = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 10);
        width = ($urandom_range(0, 1) == 0) ? 127 : $urandom_range(7, 24);
        base = $urandom_range(0, 127 - width);
        for (int i = 0; i < n_pts; i++) begin
          if (used_keys.size() > 0 && $urandom_range(0, 9) == 0)
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
          else
            k = base + $urandom_range(0, width);
          add_item(KIND_APPEND, k, pick_amp());
          used_keys.insert(used_keys.size(), k);
        end
        n_q = $urandom_range(2, 12);
        for (int i = 0; i < n_q; i++) begin
          case ($urandom_range(0, 2))
            0: k = $urandom_range(0, 127);
            1: begin
              if (used_keys.size() > 0)
                k = used_keys[$urandom_range(0, used_keys.size() - 1)]
                    + int'($urandom_range(0, 2)) - 1;
              else
                k = $urandom_range(0, 127);
            end
            default: k = base + $urandom_range(0, width);
          endcase
          if (k < 0) k = 0;
          if (k > 127) k = 127;
          add_item(KIND_QUERY, k, $urandom);
        end
      end
    end
    items_total = pending_items.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (items_accepted != items_total) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items in %0d cycles: %0d queries, %0d interpolated",
             items_total, cycle_count, query_count, interp_count);
    $display("append rejects: %0d duplicate, %0d table full", dup_count, full_count);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/bpli_pkg.sv
hdl/bpli_ram.sv
hdl/bpli_datapath.sv
hdl/bpli_ctrl.sv
hdl/breakpoint_linear_interpolator.sv
verif/breakpoint_linear_interpolator_tb.sv
